// File: design/uls_pkg.sv
// shared types and constants of the utf8 letter span finder
`timescale 1ns / 1ps

package uls_pkg;

  localparam int MaxWordBytes = 256;
  localparam int PosW         = $clog2(MaxWordBytes + 1);
  localparam int StartW       = $clog2(MaxWordBytes);
  localparam int CpW          = 21;

  typedef struct packed {
    logic [7:0] word_byte;
    logic       end_of_word;
  } uls_in_t;

  typedef struct packed {
    logic       has_letters;
    logic [7:0] letter_start;
    logic [8:0] letter_end;
    logic       trailing_hyphen;
    logic       too_long;
  } uls_out_t;

  typedef struct packed {
    logic              letter;
    logic              hyphen;
    logic [StartW-1:0] start;
    logic [PosW-1:0]   stop;
    logic              over;
  } uls_ev_t;

endpackage

// File: design/utf8_letter_span_finder.sv
// result: a word's result is registered in the result register once its final byte leaves the input register
// throughput: one byte per cycle, set by the single decode step between the
// input register and the result register; a final byte waits only while the
// result register still holds an untaken result
// reset: asynchronous active-low reset clears all decode and span state and the valids
`timescale 1ns / 1ps

module utf8_letter_span_finder import uls_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  uls_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output uls_out_t out_word_o
);

  logic    st_valid;
  uls_in_t st_word;
  logic    out_free;
  logic    adv;
  uls_ev_t ev;

  assign out_free = !out_valid_o || !out_stall_i;
  assign adv      = st_valid && (!st_word.end_of_word || out_free);

  uls_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .adv_i      (adv),
    .valid_o    (st_valid),
    .word_o     (st_word)
  );

  uls_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .word_i (st_word),
    .ev_o   (ev)
  );

  uls_span u_span (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .eow_i       (st_word.end_of_word),
    .ev_i        (ev),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// File: design/uls_in_stage.sv
// input register that holds one accepted byte until it is processed
`timescale 1ns / 1ps

module uls_in_stage import uls_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  uls_in_t in_word_i,
  input  logic    adv_i,
  output logic    valid_o,
  output uls_in_t word_o
);

  logic    valid_q, valid_d;
  uls_in_t word_q;
  logic    load;

  assign in_stall_o = valid_q && !adv_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// File: design/uls_decode.sv
// utf8 sequence decoder with byte offsets and codepoint classification
`timescale 1ns / 1ps

module uls_decode import uls_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  uls_in_t word_i,
  output uls_ev_t ev_o
);

  localparam logic [CpW-1:0] HyAscii   = CpW'(32'h002D);
  localparam logic [CpW-1:0] HyArmen   = CpW'(32'h058A);
  localparam logic [CpW-1:0] HyHyphen  = CpW'(32'h2010);
  localparam logic [CpW-1:0] HyNobreak = CpW'(32'h2011);
  localparam logic [CpW-1:0] HyDouble  = CpW'(32'h2E17);
  localparam logic [CpW-1:0] HySmall   = CpW'(32'hFE63);
  localparam logic [CpW-1:0] HyFull    = CpW'(32'hFF0D);

  function automatic logic is_letter(input logic [CpW-1:0] c);
    return (c >= CpW'(32'h30) && c <= CpW'(32'h39)) ||
           (c >= CpW'(32'h41) && c <= CpW'(32'h5A)) ||
           (c >= CpW'(32'h61) && c <= CpW'(32'h7A)) ||
           (c >= CpW'(32'h00C0) && c <= CpW'(32'h02AF)) ||
           (c >= CpW'(32'h0400) && c <= CpW'(32'h052F));
  endfunction

  function automatic logic is_hyphen(input logic [CpW-1:0] c);
    return c == HyAscii || c == HyArmen || c == HyHyphen || c == HyNobreak ||
           c == HyDouble || c == HySmall || c == HyFull;
  endfunction

  logic [PosW-1:0]   pos_q, pos_d;
  logic [1:0]        pend_q, pend_d;
  logic [CpW-1:0]    acc_q, acc_d;
  logic [StartW-1:0] seq_q, seq_d;

  logic [7:0]        b;
  logic              over;
  logic [StartW-1:0] start;
  logic [PosW:0]     idx_inc;
  logic [PosW-1:0]   stop;
  logic              relead;
  logic              cp_hit;
  logic [CpW-1:0]    cp;
  logic [StartW-1:0] cp_start;

  always_comb begin
    b        = word_i.word_byte;
    over     = pos_q >= PosW'(MaxWordBytes);
    start    = over ? StartW'(MaxWordBytes - 1) : StartW'(pos_q);
    idx_inc  = {1'b0, pos_q} + (PosW + 1)'(1);
    stop     = (idx_inc < (PosW + 1)'(MaxWordBytes)) ? PosW'(idx_inc)
                                                    : PosW'(MaxWordBytes);
    pend_d   = pend_q;
    acc_d    = acc_q;
    seq_d    = seq_q;
    relead   = 1'b1;
    cp_hit   = 1'b0;
    cp       = '0;
    cp_start = start;

    if (pend_q != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        relead = 1'b0;
        acc_d  = {acc_q[CpW-7:0], b[5:0]};
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          cp_hit   = 1'b1;
          cp       = acc_d;
          cp_start = seq_q;
        end
      end else begin
        pend_d = 2'd0;
      end
    end

    if (relead) begin
      if (!b[7]) begin
        cp_hit   = 1'b1;
        cp       = CpW'(b);
        cp_start = start;
      end else if (b[7:5] == 3'b110) begin
        acc_d  = CpW'(b[4:0]);
        pend_d = 2'd1;
        seq_d  = start;
      end else if (b[7:4] == 4'b1110) begin
        acc_d  = CpW'(b[3:0]);
        pend_d = 2'd2;
        seq_d  = start;
      end else if (b[7:3] == 5'b11110) begin
        acc_d  = CpW'(b[2:0]);
        pend_d = 2'd3;
        seq_d  = start;
      end
    end

    pos_d = stop;

    ev_o.letter = cp_hit && is_letter(cp);
    ev_o.hyphen = cp_hit && is_hyphen(cp);
    ev_o.start  = cp_start;
    ev_o.stop   = stop;
    ev_o.over   = over;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pend_q <= 2'd0;
      acc_q  <= '0;
      seq_q  <= '0;
    end else if (adv_i) begin
      if (word_i.end_of_word) begin
        pos_q  <= '0;
        pend_q <= 2'd0;
        acc_q  <= '0;
        seq_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        pend_q <= pend_d;
        acc_q  <= acc_d;
        seq_q  <= seq_d;
      end
    end
  end

endmodule

// File: design/uls_span.sv
// letter span tracking and the result register
`timescale 1ns / 1ps

module uls_span import uls_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     eow_i,
  input  uls_ev_t  ev_i,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output uls_out_t out_word_o
);

  function automatic logic [7:0] clamp_start(input logic [StartW-1:0] v);
    return (32'(v) > 32'd255) ? 8'd255 : 8'(v);
  endfunction

  function automatic logic [8:0] clamp_end(input logic [PosW-1:0] v);
    return (32'(v) > 32'd256) ? 9'd256 : 9'(v);
  endfunction

  logic              seen_q, seen_d;
  logic [StartW-1:0] first_q, first_d;
  logic [PosW-1:0]   last_q, last_d;
  logic              hyph_q, hyph_d;
  logic              over_q, over_d;
  logic              out_valid_q, out_valid_d;
  uls_out_t          out_q, res;
  logic              emit;

  assign emit = adv_i && eow_i;

  always_comb begin
    seen_d  = seen_q;
    first_d = first_q;
    last_d  = last_q;
    hyph_d  = hyph_q;
    over_d  = over_q | ev_i.over;
    if (ev_i.letter) begin
      if (!seen_q) begin
        first_d = ev_i.start;
      end
      seen_d = 1'b1;
      last_d = ev_i.stop;
      hyph_d = 1'b0;
    end else if (ev_i.hyphen && seen_q) begin
      hyph_d = 1'b1;
    end

    res.has_letters     = seen_d;
    res.letter_start    = seen_d ? clamp_start(first_d) : 8'd0;
    res.letter_end      = seen_d ? clamp_end(last_d) : 9'd0;
    res.trailing_hyphen = seen_d && hyph_d;
    res.too_long        = over_d;

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      first_q     <= '0;
      last_q      <= '0;
      hyph_q      <= 1'b0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (adv_i) begin
        if (eow_i) begin
          seen_q  <= 1'b0;
          first_q <= '0;
          last_q  <= '0;
          hyph_q  <= 1'b0;
          over_q  <= 1'b0;
        end else begin
          seen_q  <= seen_d;
          first_q <= first_d;
          last_q  <= last_d;
          hyph_q  <= hyph_d;
          over_q  <= over_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: design/uls_checker.sv
// port checks of the utf8 letter span finder and their bind
`timescale 1ns / 1ps

module uls_checker import uls_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input uls_in_t  in_word_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input uls_out_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  a_no_letter_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.has_letters |->
      out_word_o.letter_start == 8'd0 && out_word_o.letter_end == 9'd0 &&
      !out_word_o.trailing_hyphen)
    else $error("span fields set in a word without letters");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.has_letters |->
      out_word_o.letter_end > 9'(out_word_o.letter_start))
    else $error("letter span end not after its start");

endmodule

bind utf8_letter_span_finder uls_checker u_uls_checker (.*);
